// ===== design/base64url_stream_encoder_defines.svh =====
// assertion macros for the base64url stream encoder
`ifndef BASE64URL_STREAM_ENCODER_DEFINES_SVH
`define BASE64URL_STREAM_ENCODER_DEFINES_SVH

// checked only while out of reset
`define B64U_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define B64U_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/b64u_pkg.sv =====
`default_nettype none
package b64u_pkg;

  localparam int unsigned GroupW = 6;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CarryW = 4;

  typedef enum logic [1:0] {
    PH_EMPTY = 2'd0,
    PH_TWO   = 2'd1,
    PH_FOUR  = 2'd2,
    PH_BAD   = 2'd3
  } phase_t;

  // work for the back end: one or two groups per accepted byte
  typedef struct packed {
    logic [GroupW-1:0] grp0;
    logic [GroupW-1:0] grp1;
    logic              two;
    logic              last;
  } job_t;

  function automatic logic [ByteW-1:0] b64u_char(input logic [GroupW-1:0] g);
    logic [ByteW-1:0] v;
    v = {2'b00, g};
    if (g < 6'd26) begin
      b64u_char = 8'h41 + v;
    end else if (g < 6'd52) begin
      b64u_char = 8'h61 + v - 8'd26;
    end else if (g < 6'd62) begin
      b64u_char = 8'h30 + v - 8'd52;
    end else if (g == 6'd62) begin
      b64u_char = 8'h2d;
    end else begin
      b64u_char = 8'h5f;
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/base64url_stream_encoder.sv =====
// path: an accepted byte goes into the job queue, then its first character into the output register
// throughput: one byte per cycle while the queue has room, one character per cycle out while out_tready is high
// sustained: limited by the single-character output register, as three bytes make four characters
// reset: synchronous active-low rst_n empties the queue, clears the held bits and the output valid
`default_nettype none
module base64url_stream_encoder
  import b64u_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_char
  output logic            out_tlast
);

  job_t front_job;
  job_t head_job;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;

  b64u_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_tdata),
    .eom       (in_tlast),
    .job       (front_job)
  );

  b64u_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head_job),
    .empty     (q_empty)
  );

  b64u_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (head_job),
    .job_avail (!q_empty),
    .job_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_final (out_tlast)
  );

endmodule
`default_nettype wire

// ===== design/b64u_fifo.sv =====
`default_nettype none
module b64u_fifo
  import b64u_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output job_t      head,
  output logic      empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FullCnt);
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/b64u_front.sv =====
`default_nettype none
module b64u_front
  import b64u_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [ByteW-1:0] data_byte,
  input  wire logic             eom,
  output job_t                  job
);

  phase_t            phase_r, phase_nxt;
  logic [CarryW-1:0] carry_r, carry_nxt;

  always_comb begin
    job       = '0;
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    case (phase_r)
      PH_TWO: begin
        job.grp0  = {carry_r[1:0], data_byte[7:4]};
        job.grp1  = {data_byte[3:0], 2'b00};
        job.two   = eom;
        carry_nxt = data_byte[3:0];
        phase_nxt = PH_FOUR;
      end
      PH_FOUR: begin
        job.grp0  = {carry_r, data_byte[7:6]};
        job.grp1  = data_byte[5:0];
        job.two   = 1'b1;
        carry_nxt = '0;
        phase_nxt = PH_EMPTY;
      end
      default: begin
        job.grp0  = data_byte[7:2];
        job.grp1  = {data_byte[1:0], 4'b0000};
        job.two   = eom;
        carry_nxt = {2'b00, data_byte[1:0]};
        phase_nxt = PH_TWO;
      end
    endcase
    job.last = eom;
    if (eom) begin
      carry_nxt = '0;
      phase_nxt = PH_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_EMPTY;
      carry_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/b64u_back.sv =====
`default_nettype none
module b64u_back
  import b64u_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire job_t             job,
  input  wire logic             job_avail,
  output logic                  job_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [ByteW-1:0]      out_char,
  output logic                  out_final
);

  logic             sel_r, sel_nxt;
  logic             vld_r, vld_nxt;
  logic [ByteW-1:0] char_r, char_nxt;
  logic             fin_r, fin_nxt;
  logic             load;
  logic             tail;

  // the slot is free when empty or drained this cycle
  assign load = job_avail && (!vld_r || out_ready);
  assign tail = !job.two || sel_r;
  assign job_pop = load && tail;

  always_comb begin
    sel_nxt  = sel_r;
    vld_nxt  = vld_r && !out_ready;
    char_nxt = char_r;
    fin_nxt  = fin_r;
    if (load) begin
      vld_nxt  = 1'b1;
      char_nxt = b64u_char(sel_r ? job.grp1 : job.grp0);
      fin_nxt  = job.last && tail;
      sel_nxt  = !tail;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    fin_r  <= fin_nxt;
  end

  assign out_valid = vld_r;
  assign out_char  = char_r;
  assign out_final = fin_r;

endmodule
`default_nettype wire

// ===== design/b64u_checker.sv =====
`default_nettype none
`include "base64url_stream_encoder_defines.svh"
module b64u_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  `B64U_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_tvalid && in_tready, "reset left output busy")
  `B64U_ASSERT_ALWAYS(a_no_spurious, clk, (!rst_n ##1 (rst_n && !(in_tvalid && in_tready))) |=> !out_tvalid, "character without input beat")
  `B64U_ASSERT(a_stall_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)), "stalled output beat changed")

endmodule

bind base64url_stream_encoder b64u_checker u_b64u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
  import b64u_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } enc_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;  // [7:0] data_byte
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [7:0] out_char
  logic       out_tlast;

  enc_char_t  pending_chars[$];
  logic [3:0] enc_carry = '0;
  phase_t     enc_phase = PH_EMPTY;
  string      url_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  int  mismatches = 0;
  int  bytes_sent = 0;
  int  cycles = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  tx_gaps = 1'b0;
  bit  rx_stalls = 1'b0;

  base64url_stream_encoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // expected characters for one accepted beat, state carried across beats
  function automatic void encode_byte(input logic [7:0] b, input logic eom);
    logic [5:0] grp[3];
    logic [3:0] keep;
    int         n;
    int         held;
    enc_char_t  c;
    n = 0;
    case (enc_phase)
      PH_TWO: begin
        grp[0] = {enc_carry[1:0], b[7:4]};
        n = 1;
        keep = b[3:0];
        held = 4;
      end
      PH_FOUR: begin
        grp[0] = {enc_carry, b[7:6]};
        grp[1] = b[5:0];
        n = 2;
        keep = 4'h0;
        held = 0;
      end
      default: begin
        grp[0] = b[7:2];
        n = 1;
        keep = {2'b00, b[1:0]};
        held = 2;
      end
    endcase
    if (eom) begin
      if (held == 2) begin
        grp[n] = {keep[1:0], 4'h0};
        n = n + 1;
      end else if (held == 4) begin
        grp[n] = {keep, 2'b00};
        n = n + 1;
      end
      enc_carry = 4'h0;
      enc_phase = PH_EMPTY;
    end else begin
      enc_carry = keep;
      enc_phase = (held == 2) ? PH_TWO : ((held == 4) ? PH_FOUR : PH_EMPTY);
    end
    for (int k = 0; k < n; k++) begin
      c.code = url_alphabet[grp[k]];
      c.last = eom && (k == n - 1);
      pending_chars.insert(pending_chars.size(), c);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at cycle %0d: %s got %02h expected %02h", cycles, what, got, want);
    mismatches++;
  endtask

  // predict on input beats, check output beats
  always @(posedge clk) begin
    enc_char_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        encode_byte(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (pending_chars.size() == 0) begin
          report_mismatch("unexpected char", out_tdata, 8'h00);
        end else begin
          want = pending_chars.pop_front();
          if (out_tdata !== want.code) begin
            report_mismatch("out_char", out_tdata, want.code);
          end
          if (out_tlast !== want.last) begin
            report_mismatch("final_char", {7'd0, out_tlast}, {7'd0, want.last});
          end
        end
      end
    end
  end

  // receiver: long hold-off, random stalls or always ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_stalls && $urandom_range(0, 99) < 30) begin
      out_tready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eom);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eom;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'($urandom_range(0, 255));
      in_tlast <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic test_directed();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    // one-byte messages, two held bits at the end
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // full groups of dash and underscore, nothing held at the end
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // four held bits at the end, then messages ending with two, none and four held bits
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b1);
    drain();
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    hold_left = 300;
    send_message(24);
    send_message(5);
    drain();
  endtask

  task automatic test_no_idle();
    int start;
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    start = bytes_sent;
    while (bytes_sent - start < 200) begin
      send_message($urandom_range(1, 9));
    end
    drain();
  endtask

  task automatic test_random_messages();
    int r;
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    while (bytes_sent < 1350) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        send_message($urandom_range(1, 6));
      end else if (r < 97) begin
        send_message($urandom_range(7, 20));
      end else begin
        send_message($urandom_range(40, 64));
      end
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_no_idle();
    test_random_messages();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
